// ----- rtl/dro_pkg.sv -----
package dro_pkg;

	localparam int CordicSteps = 16;
	localparam int AtanEntries = 24;
	localparam int StepsRun = (CordicSteps > AtanEntries) ? AtanEntries : CordicSteps;
	localparam int StepW = $clog2(AtanEntries + 1);
	localparam int CordW = 34;
	localparam int RateQuant = 20;
	localparam logic signed [CordW-1:0] CordicX0 = 34'sd652032874;
	localparam logic [30:0] RadToTurn = 31'd683565276;
	// reciprocal of ten, exact for 32-bit numerators with a 35-bit shift
	localparam logic [31:0] RecipTen = 32'd3435973837;

	typedef enum logic [1:0] {
		ACT_VEL   = 2'd0,
		ACT_GYRO  = 2'd1,
		ACT_TICK  = 2'd2,
		ACT_RESET = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_QUANT,
		ST_CORD,
		ST_MUL,
		ST_SER,
		ST_FIN,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic start;
	} cord_ctrl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} cord_stat_t;

	function automatic logic signed [CordW-1:0] atan_turn(input logic [StepW-1:0] i);
		logic signed [CordW-1:0] r;
		case (i)
			5'd0:  r = 34'sd536870912;
			5'd1:  r = 34'sd316933406;
			5'd2:  r = 34'sd167458907;
			5'd3:  r = 34'sd85004756;
			5'd4:  r = 34'sd42667331;
			5'd5:  r = 34'sd21354465;
			5'd6:  r = 34'sd10679838;
			5'd7:  r = 34'sd5340245;
			5'd8:  r = 34'sd2670163;
			5'd9:  r = 34'sd1335087;
			5'd10: r = 34'sd667544;
			5'd11: r = 34'sd333772;
			5'd12: r = 34'sd166886;
			5'd13: r = 34'sd83443;
			5'd14: r = 34'sd41722;
			5'd15: r = 34'sd20861;
			5'd16: r = 34'sd10430;
			5'd17: r = 34'sd5215;
			5'd18: r = 34'sd2608;
			5'd19: r = 34'sd1304;
			5'd20: r = 34'sd652;
			5'd21: r = 34'sd326;
			5'd22: r = 34'sd163;
			5'd23: r = 34'sd81;
			default: r = '0;
		endcase
		return r;
	endfunction

	// round half away from zero, then drop s bits
	function automatic logic signed [63:0] round_shift(input logic signed [63:0] p,
			input logic [5:0] s);
		logic [63:0] m;
		logic [63:0] r;
		m = p[63] ? (64'd0 - p) : p;
		r = (m + (64'd1 << (s - 6'd1))) >> s;
		return p[63] ? $signed(64'd0 - r) : $signed(r);
	endfunction

endpackage

// ----- rtl/dro_cordic.sv -----
module dro_cordic (
	input  logic                                clk,
	input  logic                                arst_n,
	input  dro_pkg::cord_ctrl_t                 ctrl,
	input  logic [15:0]                         ang,
	output dro_pkg::cord_stat_t                 stat,
	output logic signed [dro_pkg::CordW-1:0]    cos_o,
	output logic signed [dro_pkg::CordW-1:0]    sin_o
);
	localparam int W = dro_pkg::CordW;
	localparam logic signed [W-1:0] Quarter = 34'sd1073741824;
	localparam logic signed [W-1:0] Half    = 34'sd2147483648;

	logic signed [W-1:0] x_q, y_q, z_q;
	logic [dro_pkg::StepW-1:0] i_q;
	logic flip_q, busy_q, done_q;
	logic signed [W-1:0] z0;

	assign z0 = W'($signed({ang, 16'h0000}));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			i_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctrl.start) begin
				busy_q <= 1'b1;
				i_q    <= '0;
			end else if (busy_q) begin
				i_q <= i_q + 1'b1;
				if (i_q == dro_pkg::StepW'(dro_pkg::StepsRun - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			x_q <= dro_pkg::CordicX0;
			y_q <= '0;
			// fold the left half plane by half a turn
			if (z0 > Quarter) begin
				z_q <= z0 - Half;
				flip_q <= 1'b1;
			end else if (z0 < -Quarter) begin
				z_q <= z0 + Half;
				flip_q <= 1'b1;
			end else begin
				z_q <= z0;
				flip_q <= 1'b0;
			end
		end else if (busy_q) begin
			if (!z_q[W-1]) begin
				x_q <= x_q - (y_q >>> i_q);
				y_q <= y_q + (x_q >>> i_q);
				z_q <= z_q - dro_pkg::atan_turn(i_q);
			end else begin
				x_q <= x_q + (y_q >>> i_q);
				y_q <= y_q - (x_q >>> i_q);
				z_q <= z_q + dro_pkg::atan_turn(i_q);
			end
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign cos_o = flip_q ? -x_q : x_q;
	assign sin_o = flip_q ? -y_q : y_q;
endmodule

// ----- rtl/dead_reckoning_odometry.sv -----
// dead-reckoning pose integrator
// input channel in_valid/in_ready carries one word: action, linear_speed_in,
// turn_rate_in and elapsed. output channel out_valid/out_ready returns one
// word per input word: pos_x, pos_y, heading and gyro_mode after that word.
// steps: a velocity or reset word goes from acceptance straight to the done
// state; a gyro word first passes a state of rate rounding; a tick word runs
// the CORDIC (16 iterations, one per cycle, then done), a state for speed
// times sine and cosine, a bit-serial multiply over the 16 bits of elapsed,
// one bit per cycle, and a state of rounding and saturation.
// the next word can be taken in the cycle after the result is loaded; one
// word is worked on at a time, and a tick word spends most of its time in
// the CORDIC loop and the serial multiplier.
// the finished word sits in the output register; a new input word is taken
// once the result has moved there, even while it waits. when the receiver
// stalls the next result is held back until the register frees.
// reset clears speed, yaw rate, gyro mode and the pose; no word is pending.
module dead_reckoning_odometry (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         action,
	input  logic signed [15:0] linear_speed_in,
	input  logic signed [15:0] turn_rate_in,
	input  logic [15:0]        elapsed,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] pos_x,
	output logic signed [31:0] pos_y,
	output logic [15:0]        heading,
	output logic               gyro_mode
);
	localparam int W = dro_pkg::CordW;

	dro_pkg::state_t state_q, state_d;

	// architectural state
	logic signed [15:0] speed_q, yaw_q;
	logic               gyro_q;
	logic signed [31:0] x_q, y_q;
	logic [15:0]        ang_q;

	// working registers
	logic [15:0]        e_q;
	logic [4:0]         cnt_q;
	logic [7:0]         kmag_q;
	logic               kneg_q;
	logic signed [63:0] scx_q, scy_q;   // speed times trig, shifted per bit
	logic signed [63:0] accx_q, accy_q; // serial product accumulators
	logic signed [32:0] we_q;           // yaw rate times elapsed
	logic signed [63:0] hp_q;           // heading product

	logic out_valid_q;
	logic accept, out_free;

	dro_pkg::cord_ctrl_t cctrl;
	dro_pkg::cord_stat_t cstat;
	logic signed [W-1:0] cos_w, sin_w;

	dro_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (cctrl),
		.ang    (ang_q),
		.stat   (cstat),
		.cos_o  (cos_w),
		.sin_o  (sin_w)
	);

	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	// gyro rate quantising, first part: k = round(t*20/4096)
	logic signed [21:0] t20;
	logic signed [63:0] k_full;
	assign t20    = 22'(turn_rate_in) * 22'sd20;
	assign k_full = dro_pkg::round_shift(64'(t20), 6'd12);

	// second part: q = round(|k|*4096/20) = (2048|k| + 5) / 10
	logic [18:0] qnum;
	logic [50:0] qprod;
	logic [15:0] qmag;
	logic signed [15:0] qrate;
	assign qnum  = {kmag_q, 11'd0} + 19'd5;
	assign qprod = 51'(qnum) * 51'(dro_pkg::RecipTen);
	assign qmag  = qprod[50:35];
	always_comb begin
		if (kneg_q) begin
			qrate = -$signed(qmag);
		end else if (qmag[15]) begin
			qrate = 16'sh7fff;
		end else begin
			qrate = $signed(qmag);
		end
	end

	// tick finish: round products and saturate position
	logic signed [63:0] dx, dy, dh;
	logic signed [32:0] sx, sy;
	assign dx = dro_pkg::round_shift(accx_q, 6'd42);
	assign dy = dro_pkg::round_shift(accy_q, 6'd42);
	assign dh = dro_pkg::round_shift(hp_q, 6'd44);
	assign sx = 33'(x_q) + dx[32:0];
	assign sy = 33'(y_q) + dy[32:0];

	function automatic logic signed [31:0] sat33(input logic signed [32:0] s);
		logic signed [31:0] r;
		if (s[32] != s[31]) begin
			r = s[32] ? 32'sh80000000 : 32'sh7fffffff;
		end else begin
			r = s[31:0];
		end
		return r;
	endfunction

	always_comb begin
		state_d     = state_q;
		in_ready    = 1'b0;
		cctrl.start = 1'b0;
		case (state_q)
			dro_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					case (dro_pkg::action_t'(action))
						dro_pkg::ACT_GYRO: state_d = dro_pkg::ST_QUANT;
						dro_pkg::ACT_TICK: begin
							state_d     = dro_pkg::ST_CORD;
							cctrl.start = 1'b1;
						end
						default: state_d = dro_pkg::ST_DONE;
					endcase
				end
			end
			dro_pkg::ST_QUANT: state_d = dro_pkg::ST_DONE;
			dro_pkg::ST_CORD: if (cstat.done) begin
				state_d = dro_pkg::ST_MUL;
			end
			dro_pkg::ST_MUL: state_d = dro_pkg::ST_SER;
			dro_pkg::ST_SER: if (cnt_q == 5'd15) begin
				state_d = dro_pkg::ST_FIN;
			end
			dro_pkg::ST_FIN: state_d = dro_pkg::ST_DONE;
			dro_pkg::ST_DONE: if (out_free) begin
				state_d = dro_pkg::ST_IDLE;
			end
			default: state_d = dro_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= dro_pkg::ST_IDLE;
			speed_q     <= '0;
			yaw_q       <= '0;
			gyro_q      <= 1'b0;
			x_q         <= '0;
			y_q         <= '0;
			ang_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			// a new result replaces one that leaves in the same cycle
			if (state_q == dro_pkg::ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (accept) begin
				case (dro_pkg::action_t'(action))
					dro_pkg::ACT_VEL: begin
						speed_q <= linear_speed_in;
						if (!gyro_q) begin
							yaw_q <= turn_rate_in;
						end
					end
					dro_pkg::ACT_GYRO: gyro_q <= 1'b1;
					dro_pkg::ACT_RESET: begin
						x_q   <= '0;
						y_q   <= '0;
						ang_q <= '0;
					end
					default: ;
				endcase
			end
			if (state_q == dro_pkg::ST_QUANT) begin
				yaw_q <= qrate;
			end
			if (state_q == dro_pkg::ST_FIN) begin
				x_q   <= sat33(sx);
				y_q   <= sat33(sy);
				ang_q <= ang_q + dh[15:0];
			end
		end
	end

	// payload and working registers, no reset needed
	always_ff @(posedge clk) begin
		if (accept) begin
			e_q    <= elapsed;
			kneg_q <= k_full[63];
			kmag_q <= k_full[63] ? 8'(-k_full) : k_full[7:0];
		end
		case (state_q)
			dro_pkg::ST_MUL: begin
				scx_q  <= 64'(speed_q) * 64'(cos_w);
				scy_q  <= 64'(speed_q) * 64'(sin_w);
				we_q   <= 33'(yaw_q) * $signed({17'd0, e_q});
				accx_q <= '0;
				accy_q <= '0;
				cnt_q  <= '0;
			end
			dro_pkg::ST_SER: begin
				// one bit of elapsed per cycle
				if (e_q[0]) begin
					accx_q <= accx_q + scx_q;
					accy_q <= accy_q + scy_q;
				end
				scx_q <= scx_q <<< 1;
				scy_q <= scy_q <<< 1;
				e_q   <= e_q >> 1;
				cnt_q <= cnt_q + 5'd1;
				hp_q  <= 64'(we_q) * $signed({33'd0, dro_pkg::RadToTurn});
			end
			default: ;
		endcase
		if (state_q == dro_pkg::ST_DONE && out_free) begin
			pos_x     <= x_q;
			pos_y     <= y_q;
			heading   <= ang_q;
			gyro_mode <= gyro_q;
		end
	end

	assign out_valid = out_valid_q;

	// gyro mode never drops once on
	a_gyro_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		gyro_q |=> gyro_q)
		else $error("gyro mode dropped");

	// a reset word clears the pose on the next cycle
	a_reset_pose: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && action == dro_pkg::ACT_RESET) |=> (x_q == 0 && y_q == 0 && ang_q == 0))
		else $error("pose not cleared");

	// the CORDIC unit only runs while a tick is in progress
	a_cordic_scope: assert property (@(posedge clk) disable iff (!arst_n)
		cstat.busy |-> (state_q == dro_pkg::ST_CORD))
		else $error("cordic busy outside tick");
endmodule
